@@ src/one_pole_pair_bandpass_assert.svh @@
// ----------------------------------------------------------------------------
// one_pole_pair_bandpass_assert.svh
// Assertion macros shared by the bandpass RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ONE_POLE_PAIR_BANDPASS_ASSERT_SVH
`define ONE_POLE_PAIR_BANDPASS_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, clocked on clk, off while in reset
`define OPPBP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("oppbp: same-cycle check failed");

// next-cycle implication
`define OPPBP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("oppbp: next-cycle check failed");

`else

`define OPPBP_ASSERT_SAME(lbl, ante, cons)
`define OPPBP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ src/oppbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oppbp_pkg
// Types and fixed constants of the one-pole pair bandpass.
// ----------------------------------------------------------------------------
package oppbp_pkg;

	// field and state widths
	localparam int SAMPLE_W   = 16;
	localparam int POLE_W     = 15;
	localparam int HP_W       = 32;
	localparam int LP_W       = 33;
	localparam int XS_W       = 31;
	localparam int STATE_FRAC = 15;

	// config port
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_HP_POLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LP_POLE = 1'b1;

	localparam logic [POLE_W-1:0] HP_POLE_RST = 15'd31506;
	localparam logic [POLE_W-1:0] LP_POLE_RST = 15'd22125;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_HP_IN,
		S_HP_FB,
		S_LP_FB,
		S_Y,
		S_LP_IN,
		S_LP_UPD,
		S_OUT
	} state_t;

	// operand pair fed to the shared multiplier
	typedef enum logic [1:0] {
		MUL_B_HP_XS,
		MUL_A_HP_HP,
		MUL_A_LP_LP,
		MUL_B_LP_Y
	} mul_op_t;

	// per-state datapath controls
	typedef struct packed {
		logic    mul_en;
		mul_op_t mul_op;
		logic    acc_load;
		logic    hp_write;
		logic    y_write;
		logic    lp_write;
		logic    out_load;
	} ctrl_t;

endpackage

@@ src/one_pole_pair_bandpass.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_pole_pair_bandpass
// One-pole highpass followed by one-pole lowpass, int16 in and out.
// ----------------------------------------------------------------------------
// Input channel: sample_in and buffer_start, handshake in_valid / in_stall.
// A beat is taken when in_valid is high and in_stall low. buffer_start
// zeroes both filter states before that sample is filtered.
// Output channel: sample_out and clipped, handshake out_valid / out_stall.
// Poles are written over cfg_we / cfg_index / cfg_data; the user must
// do so only while idle; the block does not enforce it. After the beat
// the sequencer runs HP_IN to LP_UPD, then loads the result in OUT. Four
// products go one at a time through a single multiplier; every product is
// registered and its shift-and-add happens in a later cycle.
// in_stall is high from the input beat until the result enters the output
// register. If the receiver stalls and the output register is still full,
// the sequencer waits in its last step, so nothing is lost or repeated.
// Reset (arst_n low) clears both filter states, reloads the pole registers
// and empties the output register.
// ----------------------------------------------------------------------------
`include "one_pole_pair_bandpass_assert.svh"

module one_pole_pair_bandpass
	import oppbp_pkg::*;
#(
	parameter int COEF_FRAC_BITS = 15
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// config
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [POLE_W-1:0]          cfg_data,
	// input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                       buffer_start,
	// output channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic                       clipped
);

	// coefficient width: holds b up to 2^C and a up to the raw pole range
	localparam int CW = (COEF_FRAC_BITS + 1 > POLE_W) ? COEF_FRAC_BITS + 1 : POLE_W;
	localparam int PW = CW + 1 + LP_W;
	localparam int TW = LP_W + 2;
	localparam logic [CW-1:0] COEF_ONE = CW'(64'd1 << COEF_FRAC_BITS);
	localparam logic [CW-1:0] COEF_TOP = COEF_ONE - CW'(1);

	localparam logic signed [LP_W-1:0] OUT_HI = LP_W'(64'sd32767 <<< STATE_FRAC);
	localparam logic signed [LP_W-1:0] OUT_LO = -(LP_W'(64'sd32768 <<< STATE_FRAC));
	localparam logic signed [LP_W-1:0] TRUNC_BIAS = LP_W'((64'sd1 <<< STATE_FRAC) - 1);

	localparam logic signed [TW-1:0] HP_MAX = TW'((64'sd1 <<< (HP_W - 1)) - 1);
	localparam logic signed [TW-1:0] HP_MIN = -TW'(64'sd1 <<< (HP_W - 1));
	localparam logic signed [TW-1:0] LP_MAX = TW'((64'sd1 <<< (LP_W - 1)) - 1);
	localparam logic signed [TW-1:0] LP_MIN = -TW'(64'sd1 <<< (LP_W - 1));

	state_t state_q, state_d;
	ctrl_t  ctrl;

	logic [POLE_W-1:0] hp_pole_q, lp_pole_q;
	logic signed [XS_W-1:0] xs_q;
	logic signed [HP_W-1:0] hp_q;
	logic signed [LP_W-1:0] lp_q;
	logic signed [LP_W-1:0] y_q;
	logic signed [PW-1:0]   prod_q;
	logic signed [TW-1:0]   acc_q;
	logic                   out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic                   clipped_q;

	logic in_beat, out_free;
	logic [CW-1:0] a_hp_raw, a_lp_raw, a_hp, a_lp, b_hp, b_lp;
	logic [CW-1:0] mul_coef;
	logic signed [LP_W-1:0] mul_data;
	logic signed [PW-1:0] mul_p;
	logic signed [PW-1:0] prod_sh;
	logic signed [TW-1:0] term, sum;
	logic signed [HP_W-1:0] hp_sat;
	logic signed [LP_W-1:0] lp_sat;
	logic signed [LP_W-1:0] y_next, lp_bias;
	logic signed [SAMPLE_W-1:0] q_next;
	logic clip_next;

	assign in_beat  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_pole_q <= HP_POLE_RST;
			lp_pole_q <= LP_POLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HP_POLE: hp_pole_q <= cfg_data;
				REG_LP_POLE: lp_pole_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pole clamp to just below one, b = 1 - a
	always_comb begin
		a_hp_raw = CW'(hp_pole_q);
		a_lp_raw = CW'(lp_pole_q);
		a_hp = (a_hp_raw > COEF_TOP) ? COEF_TOP : a_hp_raw;
		a_lp = (a_lp_raw > COEF_TOP) ? COEF_TOP : a_lp_raw;
		b_hp = COEF_ONE - a_hp;
		b_lp = COEF_ONE - a_lp;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_beat) state_d = S_HP_IN;
			S_HP_IN:  state_d = S_HP_FB;
			S_HP_FB:  state_d = S_LP_FB;
			S_LP_FB:  state_d = S_Y;
			S_Y:      state_d = S_LP_IN;
			S_LP_IN:  state_d = S_LP_UPD;
			S_LP_UPD: state_d = S_OUT;
			S_OUT:    if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// per-state controls
	always_comb begin
		ctrl = '0;
		ctrl.mul_op = MUL_B_HP_XS;
		unique case (state_q)
			S_HP_IN: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = MUL_B_HP_XS;
			end
			S_HP_FB: begin
				ctrl.mul_en   = 1'b1;
				ctrl.mul_op   = MUL_A_HP_HP;
				ctrl.acc_load = 1'b1;
			end
			S_LP_FB: begin
				ctrl.mul_en   = 1'b1;
				ctrl.mul_op   = MUL_A_LP_LP;
				ctrl.hp_write = 1'b1;
			end
			S_Y: begin
				ctrl.y_write  = 1'b1;
				ctrl.acc_load = 1'b1;
			end
			S_LP_IN: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = MUL_B_LP_Y;
			end
			S_LP_UPD: ctrl.lp_write = 1'b1;
			S_OUT:    ctrl.out_load = out_free;
			default: ;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		case (ctrl.mul_op)
			MUL_B_HP_XS: begin
				mul_coef = b_hp;
				mul_data = LP_W'(xs_q);
			end
			MUL_A_HP_HP: begin
				mul_coef = a_hp;
				mul_data = LP_W'(hp_q);
			end
			MUL_A_LP_LP: begin
				mul_coef = a_lp;
				mul_data = lp_q;
			end
			default: begin
				mul_coef = b_lp;
				mul_data = y_q;
			end
		endcase
	end

	assign mul_p = $signed({1'b0, mul_coef}) * mul_data;

	// floor shift of the registered product, then accumulate and saturate
	always_comb begin
		prod_sh = prod_q >>> COEF_FRAC_BITS;
		term    = prod_sh[TW-1:0];
		sum     = acc_q + term;
		if (sum > HP_MAX)      hp_sat = HP_MAX[HP_W-1:0];
		else if (sum < HP_MIN) hp_sat = HP_MIN[HP_W-1:0];
		else                   hp_sat = sum[HP_W-1:0];
		if (sum > LP_MAX)      lp_sat = LP_MAX[LP_W-1:0];
		else if (sum < LP_MIN) lp_sat = LP_MIN[LP_W-1:0];
		else                   lp_sat = sum[LP_W-1:0];
		y_next = LP_W'(xs_q) - LP_W'(hp_q);
	end

	// int16 clamp, truncation toward zero
	always_comb begin
		lp_bias = lp_q + TRUNC_BIAS;
		clip_next = 1'b0;
		if (lp_q > OUT_HI) begin
			q_next    = 16'sh7FFF;
			clip_next = 1'b1;
		end else if (lp_q < OUT_LO) begin
			q_next    = -16'sh8000;
			clip_next = 1'b1;
		end else if (!lp_q[LP_W-1]) begin
			q_next = lp_q[STATE_FRAC +: SAMPLE_W];
		end else begin
			q_next = lp_bias[STATE_FRAC +: SAMPLE_W];
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hp_q    <= '0;
			lp_q    <= '0;
		end else begin
			state_q <= state_d;
			if (in_beat && buffer_start) begin
				hp_q <= '0;
				lp_q <= '0;
			end else begin
				if (ctrl.hp_write) hp_q <= hp_sat;
				if (ctrl.lp_write) lp_q <= lp_sat;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_beat)       xs_q   <= {sample_in, {STATE_FRAC{1'b0}}};
		if (ctrl.mul_en)   prod_q <= mul_p;
		if (ctrl.acc_load) acc_q  <= term;
		if (ctrl.y_write)  y_q    <= y_next;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			sample_out_q <= q_next;
			clipped_q    <= clip_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

	// checks
	`OPPBP_ASSERT_NEXT(a_busy_after_beat, in_beat, in_stall)
	`OPPBP_ASSERT_NEXT(a_start_clears, in_beat && buffer_start, hp_q == '0 && lp_q == '0)
	`OPPBP_ASSERT_SAME(a_clip_at_rail, out_valid_q && clipped_q, sample_out_q == 16'sh7FFF || sample_out_q == -16'sh8000)
	`OPPBP_ASSERT_NEXT(a_out_after_last, state_q == S_OUT && out_free, out_valid_q && !in_stall)

endmodule
